/* rtl/core/pcr_pkg.sv */
// ----------------------------------------------------------------------------
// Palette colour resolve package
// Shared types and constants for the palette resolver and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcr_pkg;

  // Largest squared distance; only a distance strictly below it can win.
  localparam int unsigned DistW = 18;
  localparam logic [DistW-1:0] MaxDist = DistW'(3 * 255 * 255);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       free;
  } entry_t;

  typedef enum logic [2:0] {
    OutExact   = 3'd0,
    OutAlloc   = 3'd1,
    OutClosest = 3'd2,
    OutNone    = 3'd3,
    OutRelease = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StResp = 3'b100
  } state_e;

  localparam logic OpResolve = 1'b0;
  localparam logic OpRelease = 1'b1;

endpackage

/* rtl/core/pcr_cell.sv */
// ----------------------------------------------------------------------------
// Palette ring cell
// Holds one palette entry and passes it to its neighbour when the ring turns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcr_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  pcr_pkg::entry_t nbr_i,
  input  logic            load_i,
  input  logic [23:0]     color_i,
  input  logic            set_free_i,
  output pcr_pkg::entry_t entry_o
);

  pcr_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= nbr_i;
    end else if (load_i) begin
      entry_q <= '{red: color_i[7:0], green: color_i[15:8], blue: color_i[23:16],
                   free: 1'b0};
    end else if (set_free_i) begin
      entry_q.free <= 1'b1;
    end
  end

  assign entry_o = entry_q;

endmodule

/* rtl/core/pcr_match.sv */
// ----------------------------------------------------------------------------
// Palette match unit
// Compares the entry at the head of the ring with the requested colour and
// keeps the exact hit, the highest freed slot and the closest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcr_match #(
  parameter int unsigned IdxW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic            valid_i,
  input  logic [IdxW-1:0] idx_i,
  input  pcr_pkg::entry_t entry_i,
  input  logic [23:0]     color_i,
  output logic            exact_o,
  output logic [IdxW-1:0] exact_idx_o,
  output logic            have_free_o,
  output logic [IdxW-1:0] free_idx_o,
  output logic            have_close_o,
  output logic [IdxW-1:0] close_idx_o
);

  logic [8:0]  dr, dg, db;
  logic [15:0] sr, sg, sb;
  logic [pcr_pkg::DistW-1:0] sq_dist, best_q;
  logic exact_q, have_free_q, have_close_q;
  logic [IdxW-1:0] exact_idx_q, free_idx_q, close_idx_q;

  always_comb begin
    dr = (entry_i.red >= color_i[7:0]) ? {1'b0, entry_i.red - color_i[7:0]}
                                       : {1'b0, color_i[7:0] - entry_i.red};
    dg = (entry_i.green >= color_i[15:8]) ? {1'b0, entry_i.green - color_i[15:8]}
                                          : {1'b0, color_i[15:8] - entry_i.green};
    db = (entry_i.blue >= color_i[23:16]) ? {1'b0, entry_i.blue - color_i[23:16]}
                                          : {1'b0, color_i[23:16] - entry_i.blue};
    sr = dr[7:0] * dr[7:0];
    sg = dg[7:0] * dg[7:0];
    sb = db[7:0] * db[7:0];
    sq_dist = pcr_pkg::DistW'(sr) + pcr_pkg::DistW'(sg) + pcr_pkg::DistW'(sb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_q      <= 1'b0;
      have_free_q  <= 1'b0;
      have_close_q <= 1'b0;
      best_q       <= pcr_pkg::MaxDist;
    end else if (clear_i) begin
      exact_q      <= 1'b0;
      have_free_q  <= 1'b0;
      have_close_q <= 1'b0;
      best_q       <= pcr_pkg::MaxDist;
    end else if (valid_i && !exact_q) begin
      // Once an exact hit is seen the rest of the scan is ignored.
      if (entry_i.free) begin
        have_free_q <= 1'b1;
        free_idx_q  <= idx_i;
      end else if (sq_dist < best_q) begin
        if (sq_dist == '0) begin
          exact_q     <= 1'b1;
          exact_idx_q <= idx_i;
        end else begin
          best_q       <= sq_dist;
          have_close_q <= 1'b1;
          close_idx_q  <= idx_i;
        end
      end
    end
  end

  assign exact_o      = exact_q;
  assign exact_idx_o  = exact_idx_q;
  assign have_free_o  = have_free_q;
  assign free_idx_o   = free_idx_q;
  assign have_close_o = have_close_q;
  assign close_idx_o  = close_idx_q;

endmodule

/* rtl/core/palette_color_resolve.sv */
// ----------------------------------------------------------------------------
// Palette colour resolve
// Resolves colours against a palette of up to PALETTE_SIZE entries.
// ----------------------------------------------------------------------------
// The palette lives in a ring of PALETTE_SIZE cells that turns one place per
// cycle past a single match unit. A resolve item takes one full turn of the
// ring, then the palette write and the result happen together in the response
// state, which waits for room in the output register; a release item skips the
// scan and goes straight to the response state. One item is handled at a time;
// the next one is accepted as soon as the result sits in the output register.
`timescale 1ns / 1ps

module palette_color_resolve #(
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // req_red, req_green, req_blue, entry_index
  input  logic [0:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // color_index
  output logic [2:0]  m_axis_tuser   // outcome
);

  localparam int unsigned IdxW = $clog2(PALETTE_SIZE);
  localparam int unsigned CntW = $clog2(PALETTE_SIZE + 1);
  localparam logic [CntW-1:0] Full = CntW'(PALETTE_SIZE);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PALETTE_SIZE - 1);

  pcr_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] step_q, step_d;
  logic [CntW-1:0] count_q, count_d;
  logic            op_q;
  logic [23:0]     color_q;
  logic [7:0]      eidx_q;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_idx_q, out_idx_d;
  pcr_pkg::outcome_e out_code_q, out_code_d;

  pcr_pkg::entry_t ring [PALETTE_SIZE];
  logic            shift, load_en, free_en;
  logic [IdxW-1:0] load_idx;
  logic [IdxW-1:0] free_idx_w;

  logic            m_exact, m_free, m_close;
  logic [IdxW-1:0] m_exact_idx, m_free_idx, m_close_idx;

  logic accept, out_room;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_room = !out_valid_q || m_axis_tready;
  assign shift    = (state_q == pcr_pkg::StScan);
  assign free_idx_w = eidx_q[IdxW-1:0];

  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
    pcr_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .nbr_i      (ring[(i + 1) % PALETTE_SIZE]),
      .load_i     (load_en && (load_idx == IdxW'(i))),
      .color_i    (color_q),
      .set_free_i (free_en && (free_idx_w == IdxW'(i))),
      .entry_o    (ring[i])
    );
  end

  pcr_match #(.IdxW(IdxW)) u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (accept),
    .valid_i      (shift && (CntW'(step_q) < count_q)),
    .idx_i        (step_q),
    .entry_i      (ring[0]),
    .color_i      (color_q),
    .exact_o      (m_exact),
    .exact_idx_o  (m_exact_idx),
    .have_free_o  (m_free),
    .free_idx_o   (m_free_idx),
    .have_close_o (m_close),
    .close_idx_o  (m_close_idx)
  );

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_idx_d   = out_idx_q;
    out_code_d  = out_code_q;
    load_en     = 1'b0;
    load_idx    = m_free_idx;
    free_en     = 1'b0;
    unique case (state_q)
      pcr_pkg::StIdle: begin
        if (accept) begin
          state_d = (s_axis_tuser[0] == pcr_pkg::OpRelease) ? pcr_pkg::StResp
                                                            : pcr_pkg::StScan;
          step_d  = '0;
        end
      end
      pcr_pkg::StScan: begin
        step_d = step_q + 1'b1;
        if (step_q == LastIdx) begin
          step_d  = '0;
          state_d = pcr_pkg::StResp;
        end
      end
      pcr_pkg::StResp: begin
        if (out_room) begin
          state_d     = pcr_pkg::StIdle;
          out_valid_d = 1'b1;
          out_idx_d   = '0;
          if (op_q == pcr_pkg::OpRelease) begin
            out_code_d = pcr_pkg::OutRelease;
            free_en    = ({1'b0, eidx_q} < 9'(count_q));
          end else if (m_exact) begin
            out_code_d = pcr_pkg::OutExact;
            out_idx_d  = 8'(m_exact_idx);
          end else if (m_free) begin
            out_code_d = pcr_pkg::OutAlloc;
            out_idx_d  = 8'(m_free_idx);
            load_en    = 1'b1;
          end else if (count_q == Full) begin
            out_code_d = m_close ? pcr_pkg::OutClosest : pcr_pkg::OutNone;
            out_idx_d  = m_close ? 8'(m_close_idx) : 8'd0;
          end else begin
            out_code_d = pcr_pkg::OutAlloc;
            out_idx_d  = 8'(count_q);
            load_idx   = count_q[IdxW-1:0];
            load_en    = 1'b1;
            count_d    = count_q + 1'b1;
          end
        end
      end
      default: state_d = pcr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcr_pkg::StIdle;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser[0];
      color_q <= s_axis_tdata[23:0];
      eidx_q  <= s_axis_tdata[31:24];
    end
    out_idx_q  <= out_idx_d;
    out_code_q <= out_code_d;
  end

  assign s_axis_tready = (state_q == pcr_pkg::StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_idx_q;
  assign m_axis_tuser  = out_code_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full) else $error("palette count beyond size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1)
    else $error("palette count moved by other than one");

  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != pcr_pkg::StScan |-> step_q == '0)
    else $error("ring not back home outside a scan");

  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pcr_pkg::OutRelease ||
                      m_axis_tuser == pcr_pkg::OutNone) |-> m_axis_tdata == 8'd0)
    else $error("release or none result with non-zero index");

endmodule

/* verif/palette_color_resolve_tb.sv */
// ----------------------------------------------------------------------------
// Palette colour resolve testbench
// Drives resolve and release items through the stream ports, predicts each
// result from a behavioural palette kept here, and checks results in order
// under several phases of random idling and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_color_resolve_tb;

  localparam int unsigned PalSize   = 256;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry;
  } req_t;

  typedef struct packed {
    logic [7:0]        index;
    pcr_pkg::outcome_e outcome;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  palette_color_resolve #(.PALETTE_SIZE(PalSize)) dut (.*);

  always #4 clk_i = ~clk_i;

  // Behavioural palette.
  logic [7:0] pal_r [PalSize];
  logic [7:0] pal_g [PalSize];
  logic [7:0] pal_b [PalSize];
  logic       pal_freed [PalSize];
  int unsigned pal_used = 0;

  req_t  pending_items[$];
  resp_t expected_results[$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_cycles = 0;

  function automatic int unsigned sq_diff(logic [7:0] a, logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  function automatic resp_t resolve_palette(req_t rq);
    resp_t       res;
    bit          have_free;
    bit          have_close;
    int unsigned free_idx;
    int unsigned close_idx;
    int unsigned best;
    int unsigned sq_dist;
    have_free = 0;
    have_close = 0;
    free_idx = 0;
    close_idx = 0;
    best = pcr_pkg::MaxDist;
    if (rq.op == pcr_pkg::OpRelease) begin
      if (rq.entry < pal_used) pal_freed[rq.entry] = 1'b1;
      res.index = '0;
      res.outcome = pcr_pkg::OutRelease;
      return res;
    end
    for (int unsigned c = 0; c < pal_used; c++) begin
      if (pal_freed[c]) begin
        have_free = 1;
        free_idx = c;
      end else begin
        sq_dist = sq_diff(pal_r[c], rq.red) + sq_diff(pal_g[c], rq.green)
                + sq_diff(pal_b[c], rq.blue);
        if (sq_dist < best) begin
          if (sq_dist == 0) begin
            res.index = c[7:0];
            res.outcome = pcr_pkg::OutExact;
            return res;
          end
          best = sq_dist;
          have_close = 1;
          close_idx = c;
        end
      end
    end
    if (!have_free) begin
      if (pal_used >= PalSize) begin
        res.index = have_close ? close_idx[7:0] : 8'd0;
        res.outcome = have_close ? pcr_pkg::OutClosest : pcr_pkg::OutNone;
        return res;
      end
      free_idx = pal_used;
      pal_used++;
    end
    pal_r[free_idx] = rq.red;
    pal_g[free_idx] = rq.green;
    pal_b[free_idx] = rq.blue;
    pal_freed[free_idx] = 1'b0;
    res.index = free_idx[7:0];
    res.outcome = pcr_pkg::OutAlloc;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: one item per handshake; valid dropped when nothing is pending or on a random idle.
  always @(posedge clk_i) begin
    req_t rq;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          rq = pending_items.pop_front();
          expected_results.push_back(resolve_palette(rq));
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= rq.op;
          s_axis_tdata <= {rq.entry, rq.blue, rq.green, rq.red};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Prediction is made when the item is put on the bus; the block takes them
  // strictly in order, so the queue order matches.
  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected index", m_axis_tdata, 8'd0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.index) report_mismatch("index", m_axis_tdata, want.index);
          if (m_axis_tuser !== want.outcome)
            report_mismatch("outcome", 8'(m_axis_tuser), 8'(want.outcome));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else if (rst_ni) quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic req_t mk(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] e);
    req_t rq;
    rq.op = op;
    rq.red = r;
    rq.green = g;
    rq.blue = b;
    rq.entry = e;
    return rq;
  endfunction

  function automatic req_t rand_item(int unsigned n_colours);
    logic [7:0] k;
    k = 8'($urandom_range(n_colours - 1));
    if ($urandom_range(99) < 25)
      return mk(pcr_pkg::OpRelease, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom_range(255)));
    if ($urandom_range(99) < 50)
      return mk(pcr_pkg::OpResolve, {k[3:0], 4'h5}, {k[7:4], 4'hA}, k ^ 8'h3C,
                8'($urandom));
    return mk(pcr_pkg::OpResolve, 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
  endfunction

  task automatic drain;
    while (pending_items.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (PalSize + 10) @(posedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, exact hit, release of used, freed and out-of-range
    // entries, and reuse of the highest freed slot.
    pending_items.push_back(mk(pcr_pkg::OpRelease, 0, 0, 0, 0));
    pending_items.push_back(mk(pcr_pkg::OpResolve, 0, 0, 0, 8'hFF));
    pending_items.push_back(mk(pcr_pkg::OpResolve, 255, 255, 255, 0));
    pending_items.push_back(mk(pcr_pkg::OpResolve, 0, 0, 0, 0));
    pending_items.push_back(mk(pcr_pkg::OpResolve, 255, 255, 255, 0));
    pending_items.push_back(mk(pcr_pkg::OpResolve, 8'h55, 8'hAA, 8'h0F, 0));
    pending_items.push_back(mk(pcr_pkg::OpRelease, 0, 0, 0, 1));
    pending_items.push_back(mk(pcr_pkg::OpRelease, 0, 0, 0, 1));
    pending_items.push_back(mk(pcr_pkg::OpRelease, 8'hFF, 8'hFF, 8'hFF, 0));
    pending_items.push_back(mk(pcr_pkg::OpRelease, 0, 0, 0, 200));
    pending_items.push_back(mk(pcr_pkg::OpRelease, 0, 0, 0, 255));
    pending_items.push_back(mk(pcr_pkg::OpResolve, 255, 255, 255, 0));
    pending_items.push_back(mk(pcr_pkg::OpResolve, 1, 2, 3, 0));
    pending_items.push_back(mk(pcr_pkg::OpResolve, 8'hAA, 8'h55, 8'hF0, 8'hAA));
    drain();

    // Random phases; the palette fills up at the end of the first one, after
    // which closest outcomes appear.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 65 : 37) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 65 : 37) : 0;
      for (int i = 0; i < 110; i++) pending_items.push_back(rand_item(ph < 2 ? 64 : 256));
      if (ph == 0) begin
        hold_cycles = 3000;
        // Fill the palette to its end so the full-palette paths are reached.
        for (int i = 0; i < 200; i++)
          pending_items.push_back(mk(pcr_pkg::OpResolve, 8'($urandom), 8'($urandom),
                                     8'($urandom), 0));
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/pcr_pkg.sv
rtl/core/pcr_cell.sv
rtl/core/pcr_match.sv
rtl/core/palette_color_resolve.sv
verif/palette_color_resolve_tb.sv
